// ===== design/lir_pkg.sv =====
// Shared constants for the linear-interpolation resampler.
// Used by lir_interp, linear_interp_resampler and lir_checker; no dependencies.
`default_nettype none

package lir_pkg;

   // fraction bits of the phase accumulator and of the step register
   localparam int FRAC_BITS = 16;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 20;
   localparam int CLIP_W   = 15;
   localparam int PEND_W   = 4;
   localparam int MAX_RUN  = 16;
   localparam int RUN_W    = $clog2(MAX_RUN);

   // interpolation datapath widths
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;
   localparam int ACC_W  = FRAC_BITS + SAMPLE_W + 3;
   localparam int QUO_W  = ACC_W - FRAC_BITS;

   // phase accumulator widths
   localparam int SUM_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
   localparam int CARRY_W = SUM_W - FRAC_BITS;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = STEP_W;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LIMIT = 1'b1;

   // reset values
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
   localparam logic [CLIP_W-1:0] CLIP_RESET = CLIP_W'(32000);
   localparam logic [PEND_W-1:0] PEND_RESET = PEND_W'(1);
   localparam logic [PEND_W-1:0] PEND_MAX   = {PEND_W{1'b1}};

endpackage

`default_nettype wire

// ===== design/linear_interp_resampler.sv =====
// Linear-interpolation resampler top level: sequencer, window, phase and
// output register. Depends on lir_pkg and lir_interp.
//
// Each input sample shifts into a two-sample window and lowers the pending
// count; while the count is zero the block produces older + frac*(newer-older),
// truncated toward zero and clipped to +/- clip_limit, then advances the phase
// by phase_step and takes the integer carry (saturated at 15) as the new count.
// An input is accepted in the idle state; each result then takes a multiply
// state and an add/clip state into the output register, for 0 to 16 results
// per input, and waits in the add/clip state while the output register is held.
// The single multiplier in lir_interp forces the two states. A new input is
// taken as soon as the last result of a run is loaded, even while it awaits
// transfer. last_of_run marks the final result caused by an input. Write the
// CSRs only while the block is idle.
`default_nettype none

module linear_interp_resampler (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]    req_in_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lir_pkg::SAMPLE_W-1:0]    rsp_out_sample,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_wr_en,
   input  logic        [lir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [lir_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import lir_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [CLIP_W-1:0]          clip_ff, clip_in;
   logic signed [SAMPLE_W-1:0] older_ff, older_in;
   logic signed [SAMPLE_W-1:0] newer_ff, newer_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic [FRAC_BITS-1:0]       frac_ff, frac_in;
   logic [PEND_W-1:0]          pend_ff, pend_in;
   logic [RUN_W-1:0]           run_ff, run_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_xfer;
   logic                       out_free;
   logic [PEND_W-1:0]          pend_dec;
   logic [SUM_W-1:0]           phase_sum;
   logic [CARRY_W-1:0]         carry;
   logic [PEND_W-1:0]          pend_new;
   logic                       last;
   logic signed [SAMPLE_W-1:0] interp_value;

   lir_interp u_interp (
      .clock      (clock),
      .frac       (frac_ff),
      .diff       (diff_ff),
      .older      (older_ff),
      .clip_limit (clip_ff),
      .result     (interp_value)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign req_xfer        = req_valid && !req_stall;
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_comb begin
      pend_dec  = (pend_ff != '0) ? pend_ff - 1'b1 : pend_ff;
      phase_sum = SUM_W'(frac_ff) + SUM_W'(step_ff);
      carry     = phase_sum[SUM_W-1:FRAC_BITS];
      pend_new  = (32'(carry) > 32'(PEND_MAX)) ? PEND_MAX : PEND_W'(carry);
      last      = (pend_new != '0) || (run_ff == RUN_W'(MAX_RUN - 1));
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      clip_in       = clip_ff;
      older_in      = older_ff;
      newer_in      = newer_ff;
      diff_in       = diff_ff;
      frac_in       = frac_ff;
      pend_in       = pend_ff;
      run_in        = run_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP: step_in = csr_wr_data[STEP_W-1:0];
            CSR_CLIP_LIMIT: clip_in = csr_wr_data[CLIP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               older_in = newer_ff;
               newer_in = req_in_sample;
               diff_in  = DIFF_W'(req_in_sample) - DIFF_W'(newer_ff);
               pend_in  = pend_dec;
               run_in   = '0;
               if (pend_dec == '0) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // hold until the output register can take the result
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = interp_value;
               rsp_last_in   = last;
               frac_in       = phase_sum[FRAC_BITS-1:0];
               pend_in       = pend_new;
               run_in        = run_ff + 1'b1;
               state_in      = last ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_RESET;
         clip_ff      <= CLIP_RESET;
         older_ff     <= '0;
         newer_ff     <= '0;
         frac_ff      <= '0;
         pend_ff      <= PEND_RESET;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clip_ff      <= clip_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         frac_ff      <= frac_in;
         pend_ff      <= pend_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== design/lir_interp.sv =====
// Shared interpolation unit: registered multiply of fraction by sample delta,
// then add, truncate toward zero and clip. Depends on lir_pkg.
`default_nettype none

module lir_interp (
   input  logic                                    clock,
   input  logic        [lir_pkg::FRAC_BITS-1:0]    frac,
   input  logic signed [lir_pkg::DIFF_W-1:0]       diff,
   input  logic signed [lir_pkg::SAMPLE_W-1:0]     older,
   input  logic        [lir_pkg::CLIP_W-1:0]       clip_limit,
   output logic signed [lir_pkg::SAMPLE_W-1:0]     result
);
   import lir_pkg::*;

   localparam logic [ACC_W-1:0] FRAC_ONES = {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   logic signed [FRAC_BITS:0]  frac_s;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    older_ext;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    acc_adj;
   logic signed [QUO_W-1:0]    quo;
   logic signed [QUO_W-1:0]    lim_pos;
   logic signed [QUO_W-1:0]    lim_neg;

   assign frac_s  = $signed({1'b0, frac});
   assign prod_in = frac_s * diff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      older_ext = ACC_W'(older);
      acc       = (older_ext <<< FRAC_BITS) + ACC_W'(prod_ff);
      // bias negative values so the arithmetic shift truncates toward zero
      acc_adj   = acc + (acc[ACC_W-1] ? $signed(FRAC_ONES) : $signed({ACC_W{1'b0}}));
      quo       = QUO_W'(acc_adj >>> FRAC_BITS);
      lim_pos   = $signed(QUO_W'(clip_limit));
      lim_neg   = -lim_pos;
      if (quo > lim_pos) begin
         result = SAMPLE_W'(lim_pos);
      end else if (quo < lim_neg) begin
         result = SAMPLE_W'(lim_neg);
      end else begin
         result = SAMPLE_W'(quo);
      end
   end

endmodule

`default_nettype wire

// ===== design/lir_checker.sv =====
// Port-level checks for linear_interp_resampler, attached by bind.
// Depends on lir_pkg.
`default_nettype none

module lir_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [lir_pkg::SAMPLE_W-1:0]    req_in_sample,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [lir_pkg::SAMPLE_W-1:0]    rsp_out_sample,
   input logic                                   rsp_last_of_run
);
   import lir_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a result that is not the last of its run means the run is still going
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> req_stall)
      else $error("input taken during a run");

   // clipping is symmetric, so the most negative code never appears
   a_clip_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_sample != MOST_NEG))
      else $error("output outside symmetric clip range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_sample) && $stable(rsp_last_of_run)))
      else $error("stalled result changed");

   // a stalled input holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_in_sample)))
      else $error("stalled input changed");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_in_sample   (req_in_sample),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_sample  (rsp_out_sample),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
